@@ rtl/clipped_rect_fill_alpha_blend_core_defines.svh @@
// assertion macros for the clipped rectangle fill core
`ifndef CLIPPED_RECT_FILL_ALPHA_BLEND_CORE_DEFINES_SVH
`define CLIPPED_RECT_FILL_ALPHA_BLEND_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRFAB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CRFAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/crfab_pkg.sv @@
// shared types, constants and functions of the clipped rectangle fill core
package crfab_pkg;

  localparam int PIX_W   = 24;
  localparam int CNT_W   = 17;
  localparam int COORD_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } crfab_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_DRAIN,
    ST_RDATA,
    ST_RESULT
  } crfab_state_t;

  typedef struct packed {
    logic clearing;
    logic busy;
    logic filling;
  } crfab_status_t;

  // AABBGGRR colour to 0xRRGGBB
  function automatic logic [PIX_W-1:0] swap_red_blue(input logic [31:0] c);
    swap_red_blue = {c[7:0], c[15:8], c[23:16]};
  endfunction

  // n / 255 for n up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
    div255 = t[15:8];
  endfunction

endpackage

@@ rtl/crfab_mem.sv @@
// frame store: one write port, one registered read port
module crfab_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [crfab_pkg::PIX_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [crfab_pkg::PIX_W-1:0] rdata
);
  import crfab_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/crfab_blend.sv @@
// source-over blend of one pixel, per channel (s*a + d*(255-a)) / 255
module crfab_blend (
  input  logic [crfab_pkg::PIX_W-1:0] src,
  input  logic [7:0]                  alpha,
  input  logic [crfab_pkg::PIX_W-1:0] dst,
  output logic [crfab_pkg::PIX_W-1:0] mix
);
  import crfab_pkg::*;

  logic [7:0] inv_a;

  assign inv_a = 8'd255 - alpha;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [15:0] ps;
      logic [15:0] pd;
      ps = {8'd0, src[ch*8 +: 8]} * {8'd0, alpha};
      pd = {8'd0, dst[ch*8 +: 8]} * {8'd0, inv_a};
      mix[ch*8 +: 8] = div255(ps + pd);
    end
  end

endmodule

@@ rtl/crfab_ctrl.sv @@
// command sequencer: clearing pass, clipping, pixel walk and result register
module crfab_ctrl #(
  parameter int SURFACE_WIDTH  = 256,
  parameter int SURFACE_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_x_left,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_y_top,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_x_right,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_y_bottom,
  input  logic [31:0]                        in_colour_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crfab_pkg::PIX_W-1:0]        out_read_pixel,
  output logic [crfab_pkg::CNT_W-1:0]        out_pixels_written,
  input  logic signed [crfab_pkg::COORD_W-1:0] clip_left,
  input  logic signed [crfab_pkg::COORD_W-1:0] clip_top,
  input  logic signed [crfab_pkg::COORD_W-1:0] clip_right,
  input  logic signed [crfab_pkg::COORD_W-1:0] clip_bottom,
  output logic                               mem_we,
  output logic [$clog2(SURFACE_WIDTH*SURFACE_HEIGHT > 1 ?
                       SURFACE_WIDTH*SURFACE_HEIGHT : 2)-1:0] mem_waddr,
  output logic [crfab_pkg::PIX_W-1:0]        mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(SURFACE_WIDTH*SURFACE_HEIGHT > 1 ?
                       SURFACE_WIDTH*SURFACE_HEIGHT : 2)-1:0] mem_raddr,
  input  logic [crfab_pkg::PIX_W-1:0]        mem_rdata,
  output crfab_pkg::crfab_status_t           status
);
  import crfab_pkg::*;

  localparam int DEPTH = SURFACE_WIDTH * SURFACE_HEIGHT;
  localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int XW    = $clog2(SURFACE_WIDTH + 1);
  localparam int YW    = $clog2(SURFACE_HEIGHT + 1);
  localparam logic signed [16:0] W_S = 17'(SURFACE_WIDTH);
  localparam logic signed [16:0] H_S = 17'(SURFACE_HEIGHT);
  localparam logic signed [16:0] ZERO_S = 17'sd0;

  crfab_state_t state_r, state_nxt;

  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   req_r;
  logic signed [15:0]     rx0_r, ry0_r, rx1_r, ry1_r;
  logic [31:0]            col_r;
  logic [XW-1:0]          x0_r, x0_nxt, x1_r, x1_nxt, xc_r, xc_nxt;
  logic [YW-1:0]          y1_r, y1_nxt, yc_r, yc_nxt;
  logic [AW-1:0]          row_base_r, row_base_nxt;
  logic                   pv_r, pv_nxt;
  logic [AW-1:0]          pa_r, pa_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PIX_W-1:0]       res_pix_r, res_pix_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]       out_pix_r, out_pix_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;

  logic signed [16:0] cl, ct, cr, cb, rx0, ry0, rx1, ry1;
  logic signed [16:0] cx0, cy0, cx1a, cy1a, cx1, cy1, fx0, fy0, fx1, fy1;
  logic [7:0]         alpha;
  logic               fill_go, rd_on;
  logic [AW-1:0]      rd_addr, walk_addr;
  logic [PIX_W-1:0]   src_rgb, blend_pix;
  logic               last_x, last_y, in_xfer;

  assign in_xfer = in_valid && in_ready;

  // clip window and rectangle intersection, fill alpha and read address
  always_comb begin
    cl  = {clip_left[15], clip_left};
    ct  = {clip_top[15], clip_top};
    cr  = {clip_right[15], clip_right};
    cb  = {clip_bottom[15], clip_bottom};
    rx0 = {rx0_r[15], rx0_r};
    ry0 = {ry0_r[15], ry0_r};
    rx1 = {rx1_r[15], rx1_r};
    ry1 = {ry1_r[15], ry1_r};
    cx0  = (cl < ZERO_S) ? ZERO_S : cl;
    cy0  = (ct < ZERO_S) ? ZERO_S : ct;
    cx1a = (cr > W_S) ? W_S : cr;
    cy1a = (cb > H_S) ? H_S : cb;
    cx1  = (cx1a < cx0) ? cx0 : cx1a;
    cy1  = (cy1a < cy0) ? cy0 : cy1a;
    fx0  = (rx0 < cx0) ? cx0 : rx0;
    fy0  = (ry0 < cy0) ? cy0 : ry0;
    fx1  = (rx1 > cx1) ? cx1 : rx1;
    fy1  = (ry1 > cy1) ? cy1 : ry1;
    alpha   = 8'd255 - col_r[31:24];
    fill_go = (fx1 > fx0) && (fy1 > fy0) && (alpha != 8'd0);
    rd_on   = (rx0 >= ZERO_S) && (rx0 < W_S) && (ry0 >= ZERO_S) && (ry0 < H_S);
    rd_addr = AW'(ry0[YW-1:0] * SURFACE_WIDTH) + AW'(rx0[XW-1:0]);
  end

  assign src_rgb   = swap_red_blue(col_r);
  assign walk_addr = row_base_r + AW'(xc_r);
  assign last_x    = (xc_r + XW'(1)) == x1_r;
  assign last_y    = (yc_r + YW'(1)) == y1_r;

  crfab_blend u_blend (
    .src   (src_rgb),
    .alpha (alpha),
    .dst   (mem_rdata),
    .mix   (blend_pix)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    xc_nxt        = xc_r;
    y1_nxt        = y1_r;
    yc_nxt        = yc_r;
    row_base_nxt  = row_base_r;
    pv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    cnt_nxt       = cnt_r;
    res_pix_nxt   = res_pix_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pix_nxt   = out_pix_r;
    out_cnt_nxt   = out_cnt_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pa_r;
    mem_wdata     = blend_pix;
    mem_re        = 1'b0;
    mem_raddr     = walk_addr;

    // pending read-modify-write from the previous walk cycle
    if (pv_r) begin
      mem_we  = 1'b1;
      cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cnt_nxt     = '0;
        res_pix_nxt = '0;
        if (req_r == REQ_READ) begin
          if (rd_on) begin
            mem_re    = 1'b1;
            mem_raddr = rd_addr;
            state_nxt = ST_RDATA;
          end else begin
            state_nxt = ST_RESULT;
          end
        end else if (fill_go) begin
          x0_nxt       = fx0[XW-1:0];
          x1_nxt       = fx1[XW-1:0];
          xc_nxt       = fx0[XW-1:0];
          yc_nxt       = fy0[YW-1:0];
          y1_nxt       = fy1[YW-1:0];
          row_base_nxt = AW'(fy0[YW-1:0] * SURFACE_WIDTH);
          state_nxt    = ST_FILL;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_FILL: begin
        mem_re = 1'b1;
        pv_nxt = 1'b1;
        pa_nxt = walk_addr;
        xc_nxt = xc_r + XW'(1);
        if (last_x) begin
          xc_nxt       = x0_r;
          yc_nxt       = yc_r + YW'(1);
          row_base_nxt = row_base_r + AW'(SURFACE_WIDTH);
          if (last_y) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RDATA: begin
        res_pix_nxt = mem_rdata;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_req_type;
      rx0_r <= in_x_left;
      ry0_r <= in_y_top;
      rx1_r <= in_x_right;
      ry1_r <= in_y_bottom;
      col_r <= in_colour_word;
    end
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    xc_r       <= xc_nxt;
    y1_r       <= y1_nxt;
    yc_r       <= yc_nxt;
    row_base_r <= row_base_nxt;
    pa_r       <= pa_nxt;
    cnt_r      <= cnt_nxt;
    res_pix_r  <= res_pix_nxt;
    out_pix_r  <= out_pix_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_pixel     = out_pix_r;
  assign out_pixels_written = out_cnt_r;

  assign status.clearing = (state_r == ST_CLEAR);
  assign status.busy     = (state_r != ST_IDLE);
  assign status.filling  = (state_r == ST_FILL) || (state_r == ST_DRAIN);

endmodule

@@ rtl/clipped_rect_fill_alpha_blend_core.sv @@
// top level of the clipped rectangle fill core with source-over alpha blend
// reads on the surface pass setup, read-data and result states; reads off it skip
// read-data; a fill walks its clipped area, one pixel per cycle through the frame
// store's read/write ports, then drains; empty or transparent fills skip the walk
// one command at a time; input is taken again from the cycle the result turns valid
// reset: clearing pass over every SURFACE_WIDTH*SURFACE_HEIGHT word, no input taken
`include "clipped_rect_fill_alpha_blend_core_defines.svh"

module clipped_rect_fill_alpha_blend_core #(
  parameter int SURFACE_WIDTH  = 256,
  parameter int SURFACE_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_x_left,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_y_top,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_x_right,
  input  logic signed [crfab_pkg::COORD_W-1:0] in_y_bottom,
  input  logic [31:0]                        in_colour_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crfab_pkg::PIX_W-1:0]        out_read_pixel,
  output logic [crfab_pkg::CNT_W-1:0]        out_pixels_written,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import crfab_pkg::*;

  localparam int DEPTH = SURFACE_WIDTH * SURFACE_HEIGHT;
  localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

  logic signed [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  crfab_reg_t         reg_sel;
  logic [15:0]        rd_val;
  logic               cfg_wr;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [PIX_W-1:0]   mem_wdata, mem_rdata;
  crfab_status_t      status;

  assign pready  = 1'b1;
  assign reg_sel = crfab_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= 16'sd0;
      clip_top_r    <= 16'sd0;
      clip_right_r  <= 16'sd256;
      clip_bottom_r <= 16'sd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CLIP_LEFT:   clip_left_r   <= pwdata[15:0];
        REG_CLIP_TOP:    clip_top_r    <= pwdata[15:0];
        REG_CLIP_RIGHT:  clip_right_r  <= pwdata[15:0];
        REG_CLIP_BOTTOM: clip_bottom_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CLIP_LEFT:   rd_val = clip_left_r;
      REG_CLIP_TOP:    rd_val = clip_top_r;
      REG_CLIP_RIGHT:  rd_val = clip_right_r;
      REG_CLIP_BOTTOM: rd_val = clip_bottom_r;
      default:         rd_val = '0;
    endcase
    prdata = {{16{rd_val[15]}}, rd_val};
  end

  crfab_ctrl #(
    .SURFACE_WIDTH  (SURFACE_WIDTH),
    .SURFACE_HEIGHT (SURFACE_HEIGHT)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_x_left          (in_x_left),
    .in_y_top           (in_y_top),
    .in_x_right         (in_x_right),
    .in_y_bottom        (in_y_bottom),
    .in_colour_word     (in_colour_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_pixel     (out_read_pixel),
    .out_pixels_written (out_pixels_written),
    .clip_left          (clip_left_r),
    .clip_top           (clip_top_r),
    .clip_right         (clip_right_r),
    .clip_bottom        (clip_bottom_r),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .status             (status)
  );

  crfab_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  `CRFAB_ASSERT_IMPL(a_no_input_while_clearing, clk, rst_n, status.clearing, !in_ready, "input taken during clearing pass")
  `CRFAB_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready && status.busy, "second transfer while a command runs")
  `CRFAB_ASSERT_IMPL(a_result_kind, clk, rst_n, out_valid && (out_pixels_written != '0), out_read_pixel == '0, "result carries both a pixel and a count")
  `CRFAB_ASSERT_IMPL(a_write_owner, clk, rst_n, mem_we, status.clearing || status.filling, "frame store written outside clear or fill")

endmodule
